/* design/kwm_pkg.sv */
package kwm_pkg;

    // Default sizes of the stream store.
    localparam int MAX_STREAMS_DEF  = 8;
    localparam int STREAM_DEPTH_DEF = 256;

    // Fixed field widths.
    localparam int ID_W   = 32;
    localparam int TIME_W = 32;
    localparam int KEY_W  = ID_W + TIME_W;
    localparam int CMD_W  = 2;
    localparam int SEL_W  = 3;
    localparam int CFG_W  = 4;
    localparam int MASK_W = 8;

    // Reset value of the active stream count.
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    // Input command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_EMIT   = 2'd1,
        CMD_REWIND = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MATCH
    } state_t;

endpackage

/* design/kway_merge_unique_keys.sv */
// K-way merge of sorted (id, time) streams with duplicate removal.
// The slave beat carries a command in s_tuser (load, emit, rewind, clear)
// with the target stream; loads append {obs_id, obs_stamp} from s_tdata.
// Every accepted beat yields exactly one master beat: emits carry the
// smallest head key and the mask of streams that matched it; loads flag
// a dropped observation in overflow; every beat reports all_done.
// cfg_wr_en/cfg_wr_data set how many streams take part; write only idle.
// Sequencing: a load, rewind or clear presents its registered result after
// the execute state, an emit after the execute and match states (execute for
// the minimum tree over the heads, match for the equality match and head
// update; the banks have already read every head in the idle cycle before
// acceptance). One item is in flight at a time and the block returns to idle
// after each result, so it takes no new beat until the last one is done.
// When m_tready is low, the finished result is held in the sequencer
// until the output register is free; s_tready stays low meanwhile.
// Reset empties every stream, rewinds all heads and sets the active
// stream count to 8; the store contents are never used before written.
module kway_merge_unique_keys #(
    parameter int MAX_STREAMS  = kwm_pkg::MAX_STREAMS_DEF,
    parameter int STREAM_DEPTH = kwm_pkg::STREAM_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration: streams_in_use.
    input  logic                        cfg_wr_en,
    input  logic [kwm_pkg::CFG_W-1:0]   cfg_wr_data,
    // Slave side.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,  // obs_id[31:0], obs_stamp[63:32]
    input  logic [4:0]                  s_tuser,  // command[1:0], stream_sel[4:2]
    // Master side.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [79:0]                 m_tdata,  // key_id[31:0], key_time[63:32],
                                                  // contrib_mask[71:64], all_done[72],
                                                  // overflow[73], zero fill[79:74]
    output logic                        m_tuser   // key_valid[0]
);
    import kwm_pkg::*;

    localparam int AW = $clog2(STREAM_DEPTH);
    localparam int CW = $clog2(STREAM_DEPTH + 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  cfg_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] time_reg;

    logic [CW-1:0] count_reg [MAX_STREAMS];
    logic [CW-1:0] count_next [MAX_STREAMS];
    logic [CW-1:0] head_reg [MAX_STREAMS];
    logic [CW-1:0] head_next [MAX_STREAMS];

    logic [MAX_STREAMS-1:0]            wr_en;
    logic [MAX_STREAMS-1:0][KEY_W-1:0] rd_key;
    logic [MAX_STREAMS-1:0]            active;
    logic [MAX_STREAMS-1:0]            leaf_valid;
    logic [MAX_STREAMS-1:0]            load_hit;
    logic [MAX_STREAMS-1:0]            full;
    logic [MAX_STREAMS-1:0]            match;
    logic [MAX_STREAMS-1:0]            inv_bad;

    logic             tree_found;
    logic [KEY_W-1:0] tree_key;
    logic             found_reg;
    logic [KEY_W-1:0] min_key_reg;

    logic in_fire, slot_free, finish;
    logic res_valid, res_ovf, res_done;
    logic [MASK_W-1:0] res_mask;

    logic              m_tvalid_reg;
    logic              key_valid_reg;
    logic [ID_W-1:0]   key_id_reg;
    logic [TIME_W-1:0] key_time_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              done_reg;
    logic              ovf_reg;

    // Stream store: one bank per stream, read at that stream's head.
    genvar g;
    generate
        for (g = 0; g < MAX_STREAMS; g++)
        begin : g_bank
            kwm_bank #(
                .DEPTH (STREAM_DEPTH),
                .AW    (AW)
            ) u_bank (
                .clk     (clk),
                .wr_en   (wr_en[g]),
                .wr_addr (count_reg[g][AW-1:0]),
                .wr_data ({id_reg, time_reg}),
                .rd_addr (head_reg[g][AW-1:0]),
                .rd_data (rd_key[g])
            );
        end
    endgenerate

    // Per-stream status: active, head still unread, addressed by a load, full, matching the minimum, out of range.
    always_comb
    begin
        for (int s = 0; s < MAX_STREAMS; s++)
        begin
            active[s]     = 5'(s) < {1'b0, cfg_reg};
            leaf_valid[s] = active[s] && (head_reg[s] < count_reg[s]);
            load_hit[s]   = ({1'b0, sel_reg} == 4'(s));
            full[s]       = (count_reg[s] == CW'(STREAM_DEPTH));
            match[s]      = leaf_valid[s] && found_reg && (rd_key[s] == min_key_reg);
            inv_bad[s]    = (head_reg[s] > count_reg[s]) ||
                            (count_reg[s] > CW'(STREAM_DEPTH));
        end
    end

    kwm_min_tree #(
        .N (MAX_STREAMS)
    ) u_tree (
        .leaf_valid (leaf_valid),
        .leaf_key   (rd_key),
        .found      (tree_found),
        .min_key    (tree_key)
    );

    // Sequencer: capture, execute (or find the minimum), then match and update.
    always_comb
    begin
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE);
        in_fire    = s_tvalid && s_tready;
        slot_free  = !m_tvalid_reg || m_tready;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd_reg == CMD_EMIT)
                begin
                    state_next = ST_MATCH;
                end
                else if (slot_free)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MATCH:
            begin
                if (slot_free)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State updates and the result of the finishing command.
    always_comb
    begin
        res_valid = 1'b0;
        res_ovf   = 1'b0;
        res_mask  = '0;
        res_done  = 1'b1;
        for (int s = 0; s < MAX_STREAMS; s++)
        begin
            head_next[s]  = head_reg[s];
            count_next[s] = count_reg[s];
            wr_en[s]      = 1'b0;
        end
        if (finish)
        begin
            case (cmd_reg)
                CMD_LOAD:
                begin
                    res_ovf = !(|(load_hit & ~full));
                    for (int s = 0; s < MAX_STREAMS; s++)
                    begin
                        if (load_hit[s] && !full[s])
                        begin
                            wr_en[s]      = 1'b1;
                            count_next[s] = count_reg[s] + CW'(1);
                        end
                    end
                end
                CMD_EMIT:
                begin
                    res_valid = found_reg;
                    for (int s = 0; s < MAX_STREAMS; s++)
                    begin
                        if (match[s])
                        begin
                            head_next[s] = head_reg[s] + CW'(1);
                        end
                        if (s < MASK_W)
                        begin
                            res_mask[s] = match[s];
                        end
                    end
                end
                CMD_REWIND:
                begin
                    for (int s = 0; s < MAX_STREAMS; s++)
                    begin
                        head_next[s] = '0;
                    end
                end
                default:
                begin
                    for (int s = 0; s < MAX_STREAMS; s++)
                    begin
                        head_next[s]  = '0;
                        count_next[s] = '0;
                    end
                end
            endcase
        end
        // Done is judged on the state after this command.
        for (int s = 0; s < MAX_STREAMS; s++)
        begin
            if (active[s] && (head_next[s] < count_next[s]))
            begin
                res_done = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= CFG_RESET;
            m_tvalid_reg <= 1'b0;
            for (int s = 0; s < MAX_STREAMS; s++)
            begin
                count_reg[s] <= '0;
                head_reg[s]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            for (int s = 0; s < MAX_STREAMS; s++)
            begin
                count_reg[s] <= count_next[s];
                head_reg[s]  <= head_next[s];
            end
            if (finish)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: captured beat, minimum key, output beat.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= s_tuser[1:0];
            sel_reg  <= s_tuser[4:2];
            id_reg   <= s_tdata[31:0];
            time_reg <= s_tdata[63:32];
        end
        if (state_reg == ST_EXEC)
        begin
            found_reg   <= tree_found;
            min_key_reg <= tree_key;
        end
        if (finish)
        begin
            key_valid_reg <= res_valid;
            key_id_reg    <= res_valid ? min_key_reg[KEY_W-1:TIME_W] : '0;
            key_time_reg  <= res_valid ? min_key_reg[TIME_W-1:0] : '0;
            mask_reg      <= res_mask;
            done_reg      <= res_done;
            ovf_reg       <= res_ovf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = key_valid_reg;
    assign m_tdata  = {6'b0, ovf_reg, done_reg, mask_reg, key_time_reg, key_id_reg};

    // A head never passes its stream's count, and no count passes the depth.
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inv_bad == '0)
        else $error("stream head or count out of range");

    // A beat without a key carries a zero key and an empty mask.
    a_no_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[71:0] == 72'b0))
        else $error("key fields set without key_valid");

    // Overflow comes only from loads, keys only from emits.
    a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[73] && m_tuser))
        else $error("overflow and key_valid in one beat");

    // An accepted beat is executed in the following cycle.
    a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_EXEC))
        else $error("accepted beat not executed");

endmodule

/* design/kwm_bank.sv */
module kwm_bank #(
    parameter int DEPTH = kwm_pkg::STREAM_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic [kwm_pkg::KEY_W-1:0] wr_data,
    input  logic [AW-1:0]           rd_addr,
    output logic [kwm_pkg::KEY_W-1:0] rd_data
);
    import kwm_pkg::*;

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    // One write port and one registered read port; each entry is {id, time}.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/kwm_min_tree.sv */
module kwm_min_tree #(
    parameter int N = kwm_pkg::MAX_STREAMS_DEF
) (
    input  logic [N-1:0]                      leaf_valid,
    input  logic [N-1:0][kwm_pkg::KEY_W-1:0]  leaf_key,
    output logic                              found,
    output logic [kwm_pkg::KEY_W-1:0]         min_key
);
    import kwm_pkg::*;

    localparam int LEVELS = (N > 1) ? $clog2(N) : 1;
    localparam int LEAVES = 1 << LEVELS;

    logic [2*LEAVES-1:0]            nv;
    logic [2*LEAVES-1:0][KEY_W-1:0] nk;

    // Signed lexicographic order on {id, time}: flip both sign bits, then compare unsigned.
    function automatic logic key_lower(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        logic [KEY_W-1:0] ab;
        logic [KEY_W-1:0] bb;
        ab = {~a[KEY_W-1], a[KEY_W-2:TIME_W], ~a[TIME_W-1], a[TIME_W-2:0]};
        bb = {~b[KEY_W-1], b[KEY_W-2:TIME_W], ~b[TIME_W-1], b[TIME_W-2:0]};
        return ab < bb;
    endfunction

    // Heap-ordered tree: node i takes the smaller valid key of nodes 2i and 2i+1.
    always_comb
    begin
        nv = '0;
        nk = '0;
        for (int i = 0; i < LEAVES; i++)
        begin
            if (i < N)
            begin
                nv[LEAVES+i] = leaf_valid[i];
                nk[LEAVES+i] = leaf_key[i];
            end
        end
        for (int i = LEAVES - 1; i >= 1; i--)
        begin
            if (nv[2*i] && (!nv[2*i+1] || !key_lower(nk[2*i+1], nk[2*i])))
            begin
                nv[i] = 1'b1;
                nk[i] = nk[2*i];
            end
            else
            begin
                nv[i] = nv[2*i+1];
                nk[i] = nk[2*i+1];
            end
        end
    end

    assign found   = nv[1];
    assign min_key = nk[1];

endmodule

/* sim/kway_merge_unique_keys_test.sv */
module kway_merge_unique_keys_test;

    import kwm_pkg::*;

    // One command beat on the slave side.
    typedef struct {
        cmd_t               cmd;
        logic [SEL_W-1:0]   sel;
        logic signed [31:0] id;
        logic signed [31:0] tm;
    } obs_req_t;

    // One merged row on the master side.
    typedef struct {
        logic               key_valid;
        logic signed [31:0] key_id;
        logic signed [31:0] key_time;
        logic [MASK_W-1:0]  mask;
        logic               all_done;
        logic               overflow;
    } merge_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = CFG_RESET;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [63:0]         s_tdata = '0;   // obs_id[31:0], obs_stamp[63:32]
    logic [4:0]          s_tuser = '0;   // command[1:0], stream_sel[4:2]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [79:0]         m_tdata;        // key_id, key_time, contrib_mask, all_done,
                                         // overflow, zero fill
    logic                m_tuser;        // key_valid

    // Commands waiting to be driven, and rows the block still owes us.
    obs_req_t            pending_reqs [$];
    merge_row_t          expected_rows [$];
    obs_req_t            beat_in_flight;
    logic                beat_held = 1'b0;
    int                  queued_items = 0;
    int                  mismatches = 0;
    int                  send_gap_pct = 0;
    int                  recv_stall_pct = 0;

    // Shadow copy of the stream store, heads and the active stream count.
    logic signed [31:0]  id_mem [MAX_STREAMS_DEF][STREAM_DEPTH_DEF];
    logic signed [31:0]  time_mem [MAX_STREAMS_DEF][STREAM_DEPTH_DEF];
    int unsigned         fill [MAX_STREAMS_DEF];
    int unsigned         head [MAX_STREAMS_DEF];
    logic [CFG_W-1:0]    streams_cfg = CFG_RESET;

    kway_merge_unique_keys DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #6 clk = ~clk;

    // Applies one command to the shadow store and returns the row it yields.
    function automatic merge_row_t merge_step(obs_req_t r);
        merge_row_t         row;
        int unsigned        n;
        logic               found;
        logic signed [31:0] hid;
        logic signed [31:0] htm;
        row = '{key_valid: 1'b0, key_id: '0, key_time: '0, mask: '0,
                all_done: 1'b0, overflow: 1'b0};
        n = (streams_cfg > MAX_STREAMS_DEF) ? MAX_STREAMS_DEF : streams_cfg;
        found = 1'b0;
        case (r.cmd)
            CMD_LOAD:
            begin
                if (fill[r.sel] >= STREAM_DEPTH_DEF)
                    row.overflow = 1'b1;
                else
                begin
                    id_mem[r.sel][fill[r.sel]] = r.id;
                    time_mem[r.sel][fill[r.sel]] = r.tm;
                    fill[r.sel]++;
                end
            end
            CMD_EMIT:
            begin
                // Smallest (id, time) over the unfinished active heads.
                for (int s = 0; s < n; s++)
                begin
                    if (head[s] < fill[s])
                    begin
                        hid = id_mem[s][head[s]];
                        htm = time_mem[s][head[s]];
                        if (!found || hid < row.key_id ||
                            (hid == row.key_id && htm < row.key_time))
                        begin
                            row.key_id = hid;
                            row.key_time = htm;
                            found = 1'b1;
                        end
                    end
                end
                // Every head equal to that key contributes and moves on.
                if (found)
                begin
                    row.key_valid = 1'b1;
                    for (int s = 0; s < n; s++)
                    begin
                        if (head[s] < fill[s] && id_mem[s][head[s]] == row.key_id &&
                            time_mem[s][head[s]] == row.key_time)
                        begin
                            head[s]++;
                            row.mask[s] = 1'b1;
                        end
                    end
                end
            end
            CMD_REWIND:
            begin
                foreach (head[s])
                    head[s] = 0;
            end
            default:
            begin
                foreach (head[s])
                begin
                    head[s] = 0;
                    fill[s] = 0;
                end
            end
        endcase
        row.all_done = 1'b1;
        for (int s = 0; s < n; s++)
            if (head[s] < fill[s])
                row.all_done = 1'b0;
        return row;
    endfunction

    function automatic void push_req(cmd_t c, int sel, logic signed [31:0] id,
                                     logic signed [31:0] tm);
        obs_req_t r;
        r.cmd = c;
        r.sel = SEL_W'(sel);
        r.id = id;
        r.tm = tm;
        pending_reqs.push_back(r);
        queued_items++;
    endfunction

    // A command whose stream and data fields carry no meaning.
    function automatic void push_bare(cmd_t c);
        push_req(c, $urandom_range(7), $signed($urandom), $signed($urandom));
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Driver: presents the next pending command and updates the shadow on acceptance.
    always @(posedge clk)
    begin : driver
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (beat_held && s_tready)
            begin
                expected_rows.push_back(merge_step(beat_in_flight));
                beat_held = 1'b0;
            end
            if (!beat_held)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    beat_in_flight = pending_reqs.pop_front();
                    beat_held = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata <= {beat_in_flight.tm, beat_in_flight.id};
                    s_tuser <= {beat_in_flight.sel, beat_in_flight.cmd};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result beat with the oldest expected row.
    always @(posedge clk)
    begin : monitor
        merge_row_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_rows.size() == 0)
                begin
                    $error("result beat with no command outstanding: key_id %0h",
                           m_tdata[31:0]);
                    mismatches++;
                end
                else
                begin
                    want = expected_rows.pop_front();
                    check_field("key_valid", 32'(want.key_valid), 32'(m_tuser));
                    check_field("key_id", want.key_id, m_tdata[31:0]);
                    check_field("key_time", want.key_time, m_tdata[63:32]);
                    check_field("contrib_mask", 32'(want.mask), 32'(m_tdata[71:64]));
                    check_field("all_done", 32'(want.all_done), 32'(m_tdata[72]));
                    check_field("overflow", 32'(want.overflow), 32'(m_tdata[73]));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Waits until every command has been taken and answered.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || beat_held || expected_rows.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_streams_cfg(logic [CFG_W-1:0] v);
        wait_drained();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        streams_cfg = v;
    endtask

    // Extremes, every command and the corner cases, checked against the shadow.
    task automatic directed_items();
        push_bare(CMD_EMIT);
        push_req(CMD_LOAD, 0, 32'sh8000_0000, 32'sh8000_0000);
        push_req(CMD_LOAD, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        push_req(CMD_LOAD, 1, 32'sh8000_0000, 32'sh8000_0000);
        push_req(CMD_LOAD, 2, -32'sd1, -32'sd1);
        push_req(CMD_LOAD, 7, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_req(CMD_LOAD, 6, 32'sd0, 32'sd0);
        repeat (4) push_bare(CMD_EMIT);
        // A load behind heads that have already moved, duplicating stream 7.
        push_req(CMD_LOAD, 3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_bare(CMD_EMIT);
        push_bare(CMD_EMIT);
        push_bare(CMD_REWIND);
        push_bare(CMD_EMIT);
        // Unsorted loads in one stream: only the heads are compared.
        push_req(CMD_LOAD, 4, 32'sd5, 32'sd0);
        push_req(CMD_LOAD, 4, 32'sd2, 32'sd0);
        push_bare(CMD_EMIT);
        push_bare(CMD_EMIT);
        push_bare(CMD_CLEAR);
        push_bare(CMD_EMIT);
    endtask

    // Loads ascending keys into a random set of streams, then drains the merge.
    task automatic merge_batch();
        logic signed [31:0] cur_id;
        logic signed [31:0] cur_tm;
        logic [7:0]         used;
        int                 n_keys;
        int                 step;
        n_keys = $urandom_range(1, 5);
        used = 8'($urandom);
        case ($urandom_range(3))
            0: cur_id = 32'sh8000_0000;
            1: cur_id = 32'sh7FFF_FFFF - 32'sd30;
            2: cur_id = $signed(32'($urandom_range(2000))) - 32'sd1000;
            default: cur_id = $signed($urandom);
        endcase
        if (cur_id > 32'sh7FFF_FF00)
            cur_id = 32'sh7FFF_FF00;
        cur_tm = ($urandom_range(3) == 0) ? 32'sh8000_0000 : $signed($urandom);
        if (cur_tm > 32'sh7FFF_0000)
            cur_tm = 32'sh7FFF_0000;
        if ($urandom_range(99) < 70)
            push_bare(CMD_CLEAR);
        for (int k = 0; k < n_keys; k++)
        begin
            if (k > 0)
            begin
                step = $urandom_range(2);
                if (step == 0)
                    cur_tm = cur_tm + $signed(32'($urandom_range(1, 4096)));
                else
                begin
                    cur_id = cur_id + step;
                    cur_tm = $signed($urandom);
                    if (cur_tm > 32'sh7FFF_0000)
                        cur_tm = 32'sh7FFF_0000;
                end
            end
            for (int s = 0; s < MAX_STREAMS_DEF; s++)
                if (used[s] && $urandom_range(99) < 60)
                    push_req(CMD_LOAD, s, cur_id, cur_tm);
            if ($urandom_range(99) < 15)
                push_bare(CMD_EMIT);
        end
        repeat (n_keys + $urandom_range(2)) push_bare(CMD_EMIT);
        if ($urandom_range(99) < 40)
        begin
            push_bare(CMD_REWIND);
            repeat ($urandom_range(1, n_keys)) push_bare(CMD_EMIT);
        end
    endtask

    // Single random command with random content.
    task automatic noise_item();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            push_req(CMD_LOAD, $urandom_range(7), $signed($urandom), $signed($urandom));
        else if (pick < 8)
            push_bare(CMD_EMIT);
        else if (pick == 8)
            push_bare(CMD_REWIND);
        else
            push_bare(CMD_CLEAR);
    endtask

    task automatic random_segment(int n_items);
        int first;
        first = queued_items;
        while (queued_items - first < n_items)
        begin
            if ($urandom_range(99) < 75)
                merge_batch();
            else
                noise_item();
        end
    endtask

    // Fills one stream to its depth, then overruns it and merges part of it.
    task automatic full_stream_items();
        push_bare(CMD_CLEAR);
        for (int i = 0; i < STREAM_DEPTH_DEF; i++)
        begin
            push_req(CMD_LOAD, 5, $signed(32'(i / 3)) - 32'sd40,
                     $signed(32'((i % 3) * 65536)));
            if (i % 16 == 0)
                push_req(CMD_LOAD, 6, $signed(32'(i / 3)) - 32'sd40,
                         $signed(32'((i % 3) * 65536)));
        end
        push_req(CMD_LOAD, 5, $signed($urandom), $signed($urandom));
        push_req(CMD_LOAD, 5, $signed($urandom), $signed($urandom));
        push_req(CMD_LOAD, 6, 32'sd1000, 32'sd0);
        repeat (12) push_bare(CMD_EMIT);
        push_bare(CMD_REWIND);
        repeat (3) push_bare(CMD_EMIT);
        push_bare(CMD_CLEAR);
        push_bare(CMD_EMIT);
    endtask

    initial
    begin : stimulus
        logic [CFG_W-1:0] cfg_plan [8];
        int               gap_plan [4];
        int               stall_plan [4];
        cfg_plan = '{4'd8, 4'd15, 4'd1, 4'd0, 4'd3, 4'd9, 4'd5, 4'd8};
        gap_plan = '{0, 71, 0, 30};
        stall_plan = '{0, 0, 71, 30};
        foreach (fill[s])
        begin
            fill[s] = 0;
            head[s] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two register settings in each idling phase; the first keeps the reset value.
        for (int seg = 0; seg < 8; seg++)
        begin
            send_gap_pct = gap_plan[seg / 2];
            recv_stall_pct = stall_plan[seg / 2];
            if (seg == 0)
                directed_items();
            else
                write_streams_cfg(cfg_plan[seg]);
            random_segment(8);
        end
        full_stream_items();

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin : watchdog
        #(12 * 600000);
        $display("simulation failed");
        $finish;
    end

endmodule
